// File: design/widenc_pkg.sv
// Shared types, constants and codes of the windowed interval diff encoder.
package widenc_pkg;

   // Field widths fixed by the interface.
   localparam int INDEX_W  = 32;
   localparam int WORD_W   = 64;
   localparam int WINDOW_W = 6;

   // Window register value after reset.
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 6'd8;

   // Default for the largest window the pending buffer is sized for.
   localparam int MAX_WINDOW_DEFAULT = 56;

   // Depth of the decoupling queues.
   localparam int QUEUE_DEPTH = 2;

   // Result kind codes.
   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_DATA  = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   // Classified item handed from the front end to the back end.
   typedef struct packed {
      logic [INDEX_W-1:0] word_index;
      logic [WORD_W-1:0]  new_low;
      logic [WORD_W-1:0]  new_high;
      logic               final_pair;
      logic               low_changed;
      logic               high_changed;
   } cmd_type;

   // One result beat.
   typedef struct packed {
      kind_type           kind;
      logic [INDEX_W-1:0] position;
      logic [WORD_W-1:0]  payload;
      logic               last_of_item;
   } rsp_type;

   // Back-end sequencer steps, in the order in which they run for one item.
   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_START     = 3'd1,
      ST_FLUSH     = 3'd2,
      ST_LOW       = 3'd3,
      ST_HIGH      = 3'd4,
      ST_HOLD_LOW  = 3'd5,
      ST_HOLD_HIGH = 3'd6,
      ST_END       = 3'd7
   } back_state_type;

endpackage

// File: design/widenc_queue.sv
// Small first-in first-out queue used between the stages of the encoder.
module widenc_queue import widenc_pkg::*; #(
   parameter type item_type = cmd_type
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  item_type wr_item,
   input  logic     pop,
   output logic     empty,
   output item_type rd_item
);

   localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

   item_type          slots_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   // Status and handshake qualification.
   assign full    = (count_ff == CNTW'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_item = slots_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage holds no control state and needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= wr_item;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNTW'(QUEUE_DEPTH))
      else $error("queue occupancy beyond its depth");
   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CNTW'(1)))
      else $error("queue occupancy did not grow on a lone push");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree while empty");
`endif

endmodule

// File: design/widenc_front.sv
// Front end: accepts word pairs, compares them and queues the classified item.
module widenc_front import widenc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [INDEX_W-1:0] word_index,
   input  logic [WORD_W-1:0]  new_low,
   input  logic [WORD_W-1:0]  new_high,
   input  logic [WORD_W-1:0]  old_low,
   input  logic [WORD_W-1:0]  old_high,
   input  logic               final_pair,
   input  logic               cmd_pop,
   output logic               cmd_empty,
   output cmd_type            cmd_item
);

   cmd_type classified;

   // Compare each word against its reference and keep only what the back end needs.
   always_comb begin
      classified.word_index   = word_index;
      classified.new_low      = new_low;
      classified.new_high     = new_high;
      classified.final_pair   = final_pair;
      classified.low_changed  = (new_low != old_low);
      classified.high_changed = (new_high != old_high);
   end

   // Command queue that lets the front end run ahead of the back end.
   widenc_queue #(
      .item_type (cmd_type)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .wr_item (classified),
      .pop     (cmd_pop),
      .empty   (cmd_empty),
      .rd_item (cmd_item)
   );

endmodule

// File: design/widenc_back.sv
// Back end: run tracking, pending buffer and result sequencing.
module widenc_back import widenc_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [WINDOW_W-1:0] window_size,
   input  logic                cmd_empty,
   input  cmd_type             cmd_item,
   output logic                cmd_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output rsp_type             rsp_item
);

   localparam int DEPTH = MAX_WINDOW + 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_WINDOW + 4);

   // Work decided for one item when it leaves the command queue.
   typedef struct packed {
      logic               start;
      logic               flush;
      logic               low;
      logic               high;
      logic               hold_low;
      logic               hold_high;
      logic               close;
      logic [AW-1:0]      flush_last;
      logic [AW-1:0]      hold_low_addr;
      logic [AW-1:0]      hold_high_addr;
      logic [INDEX_W-1:0] start_pos;
      logic [INDEX_W-1:0] end_pos;
   } plan_type;

   back_state_type     state_ff, state_in;
   plan_type           plan_ff, plan_in;
   logic [WORD_W-1:0]  low_word_ff, high_word_ff;
   logic [AW-1:0]      flush_idx_ff, flush_idx_in;
   logic               run_open_ff, run_open_in;
   logic [CW-1:0]      pend_cnt_ff, pend_cnt_in;
   logic [WORD_W-1:0]  rd_data_ff;
   logic [WORD_W-1:0]  pend_mem [DEPTH];
   logic [CW-1:0]      cnt_after, win;
   logic               take_cmd, emit, oq_push, oq_full;
   back_state_type     after_now;
   rsp_type            oq_item;

   // First step that this plan still needs after step cur.
   function automatic back_state_type step_after(input back_state_type cur,
                                                 input plan_type p);
      back_state_type nxt;
      nxt = ST_IDLE;
      if (p.close && cur < ST_END) nxt = ST_END;
      if (p.hold_high && cur < ST_HOLD_HIGH) nxt = ST_HOLD_HIGH;
      if (p.hold_low && cur < ST_HOLD_LOW) nxt = ST_HOLD_LOW;
      if (p.high && cur < ST_HIGH) nxt = ST_HIGH;
      if (p.low && cur < ST_LOW) nxt = ST_LOW;
      if (p.flush && cur < ST_FLUSH) nxt = ST_FLUSH;
      if (p.start && cur < ST_START) nxt = ST_START;
      return nxt;
   endfunction

   assign take_cmd = (state_ff == ST_IDLE) && !cmd_empty;
   assign cmd_pop  = take_cmd;

   // Plan the item at the head of the command queue and the run state it leaves.
   always_comb begin
      plan_in     = '0;
      cnt_after   = '0;
      win         = (int'(window_size) > MAX_WINDOW) ? CW'(MAX_WINDOW) : CW'(window_size);
      if (!run_open_ff) begin
         if (cmd_item.low_changed || cmd_item.high_changed) begin
            plan_in.start     = 1'b1;
            plan_in.start_pos = cmd_item.low_changed ? cmd_item.word_index
                                                     : cmd_item.word_index + INDEX_W'(1);
            plan_in.low       = cmd_item.low_changed;
            plan_in.high      = cmd_item.high_changed;
            plan_in.hold_high = !cmd_item.high_changed;
            cnt_after         = cmd_item.high_changed ? '0 : CW'(1);
            plan_in.close     = cmd_item.final_pair;
         end
      end else if (cmd_item.low_changed || cmd_item.high_changed) begin
         // An unchanged low word goes out behind the pending words.
         plan_in.flush      = (pend_cnt_ff != '0);
         plan_in.flush_last = AW'(pend_cnt_ff - CW'(1));
         plan_in.low        = 1'b1;
         plan_in.high       = cmd_item.high_changed;
         plan_in.hold_high  = !cmd_item.high_changed;
         cnt_after          = cmd_item.high_changed ? '0 : CW'(1);
         plan_in.close      = (cnt_after > win) || cmd_item.final_pair;
      end else begin
         plan_in.hold_low       = 1'b1;
         plan_in.hold_high      = 1'b1;
         plan_in.hold_low_addr  = AW'(pend_cnt_ff);
         plan_in.hold_high_addr = AW'(pend_cnt_ff + CW'(1));
         cnt_after              = pend_cnt_ff + CW'(2);
         plan_in.close          = (cnt_after > win) || cmd_item.final_pair;
      end
      // Closing drops the pending words, so they need not be written.
      if (plan_in.close) begin
         plan_in.hold_low  = 1'b0;
         plan_in.hold_high = 1'b0;
      end
      plan_in.end_pos = cmd_item.word_index + INDEX_W'(2) - INDEX_W'(cnt_after);
      run_open_in     = run_open_ff;
      pend_cnt_in     = pend_cnt_ff;
      if (take_cmd) begin
         run_open_in = plan_in.close ? 1'b0 : (run_open_ff || plan_in.start);
         pend_cnt_in = plan_in.close ? '0 : cnt_after;
      end
   end

   // Result beat for the current step.
   always_comb begin
      after_now = step_after(state_ff, plan_ff);
      emit      = (state_ff == ST_START) || (state_ff == ST_FLUSH) || (state_ff == ST_LOW)
                  || (state_ff == ST_HIGH) || (state_ff == ST_END);
      oq_push   = emit && !oq_full;
      oq_item   = '0;
      oq_item.last_of_item = (after_now == ST_IDLE) || (after_now == ST_HOLD_LOW)
                             || (after_now == ST_HOLD_HIGH);
      case (state_ff)
         ST_START: begin
            oq_item.kind     = KIND_START;
            oq_item.position = plan_ff.start_pos;
         end
         ST_FLUSH: begin
            oq_item.kind    = KIND_DATA;
            oq_item.payload = rd_data_ff;
            if (flush_idx_ff != plan_ff.flush_last) begin
               oq_item.last_of_item = 1'b0;
            end
         end
         ST_LOW: begin
            oq_item.kind    = KIND_DATA;
            oq_item.payload = low_word_ff;
         end
         ST_HIGH: begin
            oq_item.kind    = KIND_DATA;
            oq_item.payload = high_word_ff;
         end
         ST_END: begin
            oq_item.kind     = KIND_END;
            oq_item.position = plan_ff.end_pos;
         end
         default: begin
            oq_item.kind = KIND_DATA;
         end
      endcase
   end

   // Next step and flush index; the index also addresses the buffer read.
   always_comb begin
      state_in     = state_ff;
      flush_idx_in = flush_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            flush_idx_in = '0;
            if (!cmd_empty) begin
               state_in = step_after(ST_IDLE, plan_in);
            end
         end
         ST_START, ST_LOW, ST_HIGH, ST_END: begin
            if (oq_push) begin
               state_in = after_now;
            end
         end
         ST_FLUSH: begin
            if (oq_push) begin
               if (flush_idx_ff == plan_ff.flush_last) begin
                  state_in = after_now;
               end else begin
                  flush_idx_in = flush_idx_ff + AW'(1);
               end
            end
         end
         ST_HOLD_LOW, ST_HOLD_HIGH: begin
            state_in = after_now;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_open_ff  <= 1'b0;
         pend_cnt_ff  <= '0;
         flush_idx_ff <= '0;
      end else begin
         state_ff     <= state_in;
         run_open_ff  <= run_open_in;
         pend_cnt_ff  <= pend_cnt_in;
         flush_idx_ff <= flush_idx_in;
      end
   end

   // Plan and words of the item in progress.
   always_ff @(posedge clock) begin
      if (take_cmd) begin
         plan_ff      <= plan_in;
         low_word_ff  <= cmd_item.new_low;
         high_word_ff <= cmd_item.new_high;
      end
   end

   // Pending buffer: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (state_ff == ST_HOLD_LOW) begin
         pend_mem[plan_ff.hold_low_addr] <= low_word_ff;
      end else if (state_ff == ST_HOLD_HIGH) begin
         pend_mem[plan_ff.hold_high_addr] <= high_word_ff;
      end
      rd_data_ff <= pend_mem[flush_idx_in];
   end

   // Output queue parts the sequencer from the receiver.
   widenc_queue #(
      .item_type (rsp_type)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (oq_push),
      .full    (oq_full),
      .wr_item (oq_item),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_item (rsp_item)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) !run_open_ff |-> (pend_cnt_ff == '0))
      else $error("pending words held while no run is open");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (flush_idx_ff <= plan_ff.flush_last))
      else $error("flush index ran past the pending words");
   assert property (@(posedge clock) disable iff (reset)
      (oq_push && state_ff == ST_END) |-> oq_item.last_of_item)
      else $error("end marker not flagged as the last beat of its item");
`endif

endmodule

// File: design/windowed_interval_diff_encoder_unit.sv
// Top level of the windowed interval diff encoder: ports, window register and stages.
//
// Usage. Word pairs enter through a queue-style port: an item is taken at a clock edge
// with req_push high and req_full low. Results leave through a queue-style port: the
// oldest beat sits on the rsp_ ports while rsp_empty is low and is taken at an edge
// with rsp_pop high. Each beat is a start marker, a data word or an end marker, and
// rsp_last_of_item marks the final beat caused by one pair. A pair that causes no
// beat produces nothing. The window register is written with csr_write_enable; the user
// must write it only while the block is idle, which the block itself does not enforce;
// values above MAX_WINDOW act as MAX_WINDOW. An item passes through the command queue
// and the sequencer registers, and its beats through the result queue. The back-end
// sequencer takes an item, then emits each result beat and parks each word in the
// pending buffer in turn; it takes no new item until it is through with the last one,
// while the command queue keeps accepting pairs until full, and a full result queue
// holds it. A pair that flushes a full buffer and closes gives up to 59 beats.
// Reset: no run is open, the window is 8 and both queues are empty; the pending buffer
// needs no clearing. When the receiver stalls, the result queue fills, the sequencer
// holds, the command queue fills and req_full rises.
module windowed_interval_diff_encoder_unit import widenc_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [INDEX_W-1:0]  req_word_index,
   input  logic [WORD_W-1:0]   req_new_low,
   input  logic [WORD_W-1:0]   req_new_high,
   input  logic [WORD_W-1:0]   req_old_low,
   input  logic [WORD_W-1:0]   req_old_high,
   input  logic                req_final_pair,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [1:0]          rsp_kind,
   output logic [INDEX_W-1:0]  rsp_position,
   output logic [WORD_W-1:0]   rsp_payload,
   output logic                rsp_last_of_item,
   input  logic                csr_write_enable,
   input  logic [WINDOW_W-1:0] csr_window_size
);

   logic [WINDOW_W-1:0] window_ff;
   logic                cmd_pop, cmd_empty;
   cmd_type             cmd_item;
   rsp_type             rsp_item;

   // Window size register.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_write_enable) begin
         window_ff <= csr_window_size;
      end
   end

   // Front end: comparison and command queue.
   widenc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .word_index (req_word_index),
      .new_low    (req_new_low),
      .new_high   (req_new_high),
      .old_low    (req_old_low),
      .old_high   (req_old_high),
      .final_pair (req_final_pair),
      .cmd_pop    (cmd_pop),
      .cmd_empty  (cmd_empty),
      .cmd_item   (cmd_item)
   );

   // Back end: run sequencing, pending buffer and result queue.
   widenc_back #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .window_size (window_ff),
      .cmd_empty   (cmd_empty),
      .cmd_item    (cmd_item),
      .cmd_pop     (cmd_pop),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_item    (rsp_item)
   );

   // Result beat fields.
   assign rsp_kind         = rsp_item.kind;
   assign rsp_position     = rsp_item.position;
   assign rsp_payload      = rsp_item.payload;
   assign rsp_last_of_item = rsp_item.last_of_item;

endmodule
